// ===== hdl/aabb_pkg.sv =====
// Package for the AABB build and overlap core: shared types, constants and opcodes.
// No dependencies.
package aabb_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int COEF_BITS_DEF  = 16;
    localparam int IO_BITS        = 32;
    localparam int CFG_BITS       = 64;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LANE_BITS      = 16;
    localparam int ACC_BITS       = 64;
    localparam int FRAC_BITS      = 16;

    typedef enum logic [1:0]
    {
        KIND_VERTEX  = 2'd0,
        KIND_OVERLAP = 2'd1,
        KIND_MERGE   = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0]
    {
        REG_COL_X = 2'd0,
        REG_COL_Y = 2'd1,
        REG_COL_Z = 2'd2,
        REG_COL_W = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MAC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_APPLY,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic load;
        logic mac_clear;
        logic mac_step;
        logic div_start;
        logic vtx_update;
        logic box_update;
        logic out_load;
    } cmd_t;

    typedef struct packed
    {
        logic       in_valid;
        logic       out_free;
        logic [1:0] kind;
        logic       mac_done;
        logic       div_done;
        logic       axes_done;
    } stat_t;

endpackage

// ===== hdl/aabb_if.sv =====
// Valid/ready channel interface with a parameterized payload.
// Depends on nothing.
interface aabb_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/aabb_build_and_overlap_core.sv =====
// Top level of the AABB build and overlap core.
// Depends on aabb_pkg, aabb_if, aabb_ctrl and aabb_datapath.
//
// Overlap, merge and unused items go from acceptance through a box update state to the result
// load, and the next item is taken back in the idle state. A vertex item passes a dispatch
// state and three multiply-accumulate steps over the matrix rows, then three divides on one
// shared restoring divider, each with a start, an iteration for each of the 80 quotient bits
// and a store of the quotient, then a box update and the result load. One result waits in an
// output register, so the next item is taken while it waits; that item holds in its last
// cycle until the waiting result is read.
module aabb_build_and_overlap_core #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = aabb_pkg::COEF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aabb_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [aabb_pkg::CFG_BITS-1:0]     cfg_data,
    aabb_if.sink                              in_ch,
    aabb_if.source                            out_ch
);
    import aabb_pkg::*;

    cmd_t  cmd;
    stat_t dstat, cstat;
    logic signed [IO_BITS-1:0] lo [3];
    logic signed [IO_BITS-1:0] hi [3];
    logic signed [IO_BITS-1:0] push [3];
    logic signed [IO_BITS-1:0] mn [3];
    logic signed [IO_BITS-1:0] mx [3];
    logic hit;

    assign lo[0] = in_ch.data.coord_x;
    assign lo[1] = in_ch.data.coord_y;
    assign lo[2] = in_ch.data.coord_z;
    assign hi[0] = in_ch.data.upper_x;
    assign hi[1] = in_ch.data.upper_y;
    assign hi[2] = in_ch.data.upper_z;

    aabb_datapath #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (dstat),
        .in_kind  (in_ch.data.kind),
        .in_first (in_ch.data.first),
        .in_lo    (lo),
        .in_hi    (hi),
        .out_hit  (hit),
        .out_push (push),
        .out_min  (mn),
        .out_max  (mx)
    );

    always_comb
    begin
        cstat          = dstat;
        cstat.in_valid = in_ch.valid;
        cstat.out_free = !out_ch.valid;
    end

    aabb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (cstat),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready)
    );

    assign out_ch.data.hit       = hit;
    assign out_ch.data.push_x    = push[0];
    assign out_ch.data.push_y    = push[1];
    assign out_ch.data.push_z    = push[2];
    assign out_ch.data.box_min_x = mn[0];
    assign out_ch.data.box_min_y = mn[1];
    assign out_ch.data.box_min_z = mn[2];
    assign out_ch.data.box_max_x = mx[0];
    assign out_ch.data.box_max_y = mx[1];
    assign out_ch.data.box_max_z = mx[2];
endmodule

// ===== hdl/aabb_div.sv =====
// Restoring divider: |n| * 2^16 / |w| with the sign of n / w applied, one quotient bit per cycle, saturated.
// Depends on aabb_pkg.
module aabb_div #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [aabb_pkg::ACC_BITS-1:0] num,
    input  logic signed [aabb_pkg::ACC_BITS-1:0] den,
    output logic                                done,
    output logic signed [COORD_BITS-1:0]        quo
);
    import aabb_pkg::*;

    localparam int QB = ACC_BITS + FRAC_BITS;
    localparam int CB = $clog2(QB + 1);

    logic [ACC_BITS-1:0] un, uw;
    logic                neg, nneg;
    logic [QB-1:0]       dvd_reg, dvd_next;
    logic [ACC_BITS:0]   rem_reg, rem_next;
    logic [ACC_BITS-1:0] dsr_reg;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next, neg_reg, nneg_reg, zero_reg;
    logic                done_reg, done_next;
    logic [ACC_BITS:0]   trial;
    logic [QB-1:0]       lim;
    logic [QB:0]         mag;

    assign neg  = num[ACC_BITS-1] ^ den[ACC_BITS-1];
    assign nneg = num[ACC_BITS-1];
    assign un   = num[ACC_BITS-1] ? (~num + 1'b1) : num;
    assign uw   = den[ACC_BITS-1] ? (~den + 1'b1) : den;
    assign trial = {rem_reg[ACC_BITS-1:0], dvd_reg[QB-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (!trial[ACC_BITS])
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[ACC_BITS-1:0], dvd_reg[QB-1]};
                dvd_next = {dvd_reg[QB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(QB);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {un, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            dsr_reg  <= uw;
            neg_reg  <= neg;
            nneg_reg <= nneg;
            zero_reg <= (uw == '0);
        end
        else
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign lim = neg_reg ? QB'({1'b1, {(COORD_BITS-1){1'b0}}})
                         : QB'({(COORD_BITS-1){1'b1}});

    always_comb
    begin
        mag = {1'b0, dvd_reg};
        if (dvd_reg > lim)
            mag = {1'b0, lim};
        if (zero_reg)
            quo = nneg_reg ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (neg_reg)
            quo = COORD_BITS'(~mag + 1'b1);
        else
            quo = COORD_BITS'(mag);
    end

    assign done = done_reg;
endmodule

// ===== hdl/aabb_datapath.sv =====
// Datapath: matrix registers, transform accumulator, divider, box state and result register.
// Depends on aabb_pkg and aabb_div.
module aabb_datapath #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = aabb_pkg::COEF_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [aabb_pkg::CFG_IDX_BITS-1:0]       cfg_idx,
    input  logic [aabb_pkg::CFG_BITS-1:0]           cfg_data,
    input  aabb_pkg::cmd_t                          cmd,
    output aabb_pkg::stat_t                         stat,
    input  logic [1:0]                              in_kind,
    input  logic                                    in_first,
    input  logic signed [aabb_pkg::IO_BITS-1:0]     in_lo [3],
    input  logic signed [aabb_pkg::IO_BITS-1:0]     in_hi [3],
    output logic                                    out_hit,
    output logic signed [aabb_pkg::IO_BITS-1:0]     out_push [3],
    output logic signed [aabb_pkg::IO_BITS-1:0]     out_min [3],
    output logic signed [aabb_pkg::IO_BITS-1:0]     out_max [3]
);
    import aabb_pkg::*;

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam int MB = COORD_BITS + COEF_BITS;

    logic [CFG_BITS-1:0]           mat_reg [4];
    logic signed [COORD_BITS-1:0]  min_reg [3];
    logic signed [COORD_BITS-1:0]  max_reg [3];
    logic signed [COORD_BITS-1:0]  lo_reg [3];
    logic signed [COORD_BITS-1:0]  hi_reg [3];
    logic [1:0]                    kind_reg;
    logic                          first_reg;
    logic signed [ACC_BITS-1:0]    acc_reg [4];
    logic [1:0]                    row_reg;
    logic [1:0]                    ax_reg;
    logic signed [COORD_BITS-1:0]  p_reg [3];
    logic                          div_done;
    logic signed [COORD_BITS-1:0]  quo;
    logic signed [MB-1:0]          prod [4];
    logic signed [ACC_BITS-1:0]    term [4];
    logic signed [ACC_BITS-1:0]    sum  [4];
    logic                          hit;
    logic signed [COORD_BITS:0]    da [3];
    logic signed [COORD_BITS:0]    db [3];
    logic signed [COORD_BITS:0]    pv [3];
    logic signed [COORD_BITS-1:0]  push [3];
    logic signed [COORD_BITS-1:0]  cur;

    function automatic logic signed [COORD_BITS-1:0] rd(input logic signed [IO_BITS-1:0] v);
        rd = COORD_BITS'(v);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] cf(input logic [CFG_BITS-1:0] c,
                                                       input logic [1:0] r);
        cf = COEF_BITS'(c >> (LANE_BITS * r));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= CFG_BITS'(64'd256);
            mat_reg[1] <= CFG_BITS'(64'd16777216);
            mat_reg[2] <= CFG_BITS'(64'd1099511627776);
            mat_reg[3] <= CFG_BITS'(64'd72057594037927936);
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_idx] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= rd(in_lo[a]);
                hi_reg[a] <= rd(in_hi[a]);
            end
            kind_reg  <= in_kind;
            first_reg <= in_first;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod[c] = lo_reg[row_reg] * cf(mat_reg[c], row_reg);
            term[c] = ACC_BITS'(prod[c]);
            sum[c]  = acc_reg[c] + term[c];
            if (!acc_reg[c][ACC_BITS-1] && !term[c][ACC_BITS-1] && sum[c][ACC_BITS-1])
                sum[c] = {1'b0, {(ACC_BITS-1){1'b1}}};
            else if (acc_reg[c][ACC_BITS-1] && term[c][ACC_BITS-1] && !sum[c][ACC_BITS-1])
                sum[c] = {1'b1, {(ACC_BITS-1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            ax_reg  <= '0;
        end
        else
        begin
            if (cmd.mac_clear)
                row_reg <= '0;
            else if (cmd.mac_step)
                row_reg <= row_reg + 1'b1;
            if (cmd.mac_clear)
                ax_reg <= '0;
            else if (div_done)
                ax_reg <= ax_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_clear)
        begin
            for (int c = 0; c < 4; c++)
                acc_reg[c] <= ACC_BITS'(cf(mat_reg[c], 2'd3)) <<< FRAC_BITS;
        end
        else if (cmd.mac_step)
        begin
            for (int c = 0; c < 4; c++)
                acc_reg[c] <= sum[c];
        end
        if (div_done)
            p_reg[ax_reg] <= quo;
    end

    aabb_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg[ax_reg]),
        .den   (acc_reg[3]),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        hit = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (min_reg[a] > hi_reg[a] || lo_reg[a] > max_reg[a])
                hit = 1'b0;
            da[a] = (COORD_BITS+1)'(max_reg[a]) - (COORD_BITS+1)'(lo_reg[a]);
            db[a] = (COORD_BITS+1)'(hi_reg[a]) - (COORD_BITS+1)'(min_reg[a]);
            pv[a] = (da[a] > db[a]) ? db[a] : -da[a];
            if (pv[a] > (COORD_BITS+1)'(CMAX))
                push[a] = CMAX;
            else if (pv[a] < (COORD_BITS+1)'(CMIN))
                push[a] = CMIN;
            else
                push[a] = COORD_BITS'(pv[a]);
        end
        cur = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= CMAX;
                max_reg[a] <= CMIN;
            end
        end
        else if (cmd.vtx_update)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (first_reg || p_reg[a] < min_reg[a])
                    min_reg[a] <= p_reg[a];
                if (first_reg || p_reg[a] > max_reg[a])
                    max_reg[a] <= p_reg[a];
            end
        end
        else if (cmd.box_update && kind_reg == KIND_MERGE)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (lo_reg[a] < min_reg[a])
                    min_reg[a] <= lo_reg[a];
                if (hi_reg[a] > max_reg[a])
                    max_reg[a] <= hi_reg[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit <= (kind_reg == KIND_OVERLAP) && hit;
            for (int a = 0; a < 3; a++)
            begin
                out_push[a] <= ((kind_reg == KIND_OVERLAP) && hit)
                               ? IO_BITS'(push[a]) : IO_BITS'(cur);
                out_min[a]  <= IO_BITS'(min_reg[a]);
                out_max[a]  <= IO_BITS'(max_reg[a]);
            end
        end
    end

    assign stat.in_valid  = 1'b0;
    assign stat.out_free  = 1'b0;
    assign stat.kind      = kind_reg;
    assign stat.mac_done  = (row_reg == 2'd2);
    assign stat.div_done  = div_done;
    assign stat.axes_done = div_done && (ax_reg == 2'd2);
endmodule

// ===== hdl/aabb_ctrl.sv =====
// Controller state machine sequencing load, transform, divide, update and output.
// Depends on aabb_pkg.
module aabb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  aabb_pkg::stat_t stat,
    output aabb_pkg::cmd_t  cmd,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready
);
    import aabb_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (stat.kind == KIND_VERTEX)
                begin
                    cmd.mac_clear = 1'b1;
                    state_next    = ST_DIV_START;
                end
                else
                begin
                    cmd.box_update = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_DIV_START:
            begin
                cmd.mac_step = 1'b1;
                if (stat.mac_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.axes_done)
                    state_next = ST_APPLY;
                else if (stat.div_done)
                    state_next = ST_UPDATE;
            end
            ST_APPLY:
            begin
                cmd.vtx_update = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
endmodule
